FILE: sv/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
package mf3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd256;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // result queue
   localparam int ODEPTH = 8;
   localparam int OPTR_W = $clog2(ODEPTH);
   localparam int OCNT_W = $clog2(ODEPTH + 1);

   // window rows and columns
   localparam logic [1:0] WIN_TOP = 2'd0;
   localparam logic [1:0] WIN_MID = 2'd1;
   localparam logic [1:0] WIN_BOT = 2'd2;
   localparam logic [1:0] COL_OLD = 2'd0;
   localparam logic [1:0] COL_CEN = 2'd1;
   localparam logic [1:0] COL_NEW = 2'd2;

   // result slots of one job, in delivery order
   localparam logic [1:0] RES_UP_INNER = 2'd0;
   localparam logic [1:0] RES_UP_EDGE  = 2'd1;
   localparam logic [1:0] RES_LO_INNER = 2'd2;
   localparam logic [1:0] RES_LO_EDGE  = 2'd3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [2:0][PIX_W-1:0] trio_type;       // [0] smallest after sort
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;  // [row][col]

   typedef struct packed {
      window_type win;
      logic [3:0] needs;       // one bit per result slot
      logic       up_top_mid;  // upper result: top row clamped to middle
      logic       lo_top_bot;  // lower result: top row clamped to bottom
      logic       frame_end;
   } job_type;

   typedef struct packed {
      pix_type median;
      logic    frame_done;
      logic    run_last;
   } rsp_type;

   function automatic trio_type sort3(input pix_type a, input pix_type b, input pix_type c);
      pix_type  lo1;
      pix_type  hi1;
      pix_type  mid;
      trio_type res;
      lo1    = (a < b) ? a : b;
      hi1    = (a < b) ? b : a;
      mid    = (hi1 < c) ? hi1 : c;
      res[0] = (lo1 < c) ? lo1 : c;
      res[1] = (lo1 > mid) ? lo1 : mid;
      res[2] = (hi1 > c) ? hi1 : c;
      return res;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      trio_type s;
      s = sort3(a, b, c);
      return s[1];
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

FILE: sv/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read before write on a shared address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/mf3_front.sv
// Front end: config registers, raster position, line stores, window and job build.
module mf3_front import mf3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  pix_type               req_pixel_in,
   output logic                  req_full,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [QCNT_W-1:0]     q_count,
   output logic                  job_push,
   output job_type               job
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        eff_w_m1;
   logic [ROW_W-1:0]        eff_h_m1;
   logic                    last_col, last_row, accept, csr_hit;
   logic [QCNT_W-1:0]       occ;

   logic       s1_valid_ff, s1_valid_in;
   pix_type    s1_px_ff;
   logic [COL_W-1:0] s1_idx_ff;
   logic       s1_first_ff, s1_fwd_ff;
   pix_type    fwd_b_ff;
   logic [3:0] s1_needs_ff, needs;
   logic       s1_up_top_mid_ff, s1_lo_top_bot_ff, s1_frame_end_ff;

   window_type win_ff, win_in;
   pix_type    a_rd, b_rd;
   trio_type   cols;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;
   assign occ       = q_count + QCNT_W'(s1_valid_ff);
   assign req_full  = occ >= QCNT_W'(QDEPTH);

   always_comb begin
      priority if (width_ff == '0) begin
         eff_w_m1 = '0;
      end else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         eff_w_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         eff_w_m1 = COL_W'(width_ff - 1'b1);
      end
      priority if (height_ff == '0) begin
         eff_h_m1 = '0;
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         eff_h_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         eff_h_m1 = ROW_W'(height_ff - 1'b1);
      end
   end

   assign last_col = col_ff >= eff_w_m1;
   assign last_row = row_ff >= eff_h_m1;

   always_comb begin
      needs[RES_UP_INNER] = (row_ff != '0) && (col_ff != '0);
      needs[RES_UP_EDGE]  = (row_ff != '0) && last_col;
      needs[RES_LO_INNER] = last_row && (col_ff != '0);
      needs[RES_LO_EDGE]  = last_row && last_col;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      csr_hit   = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
               csr_hit  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_REG_W-1:0];
               csr_hit   = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
      priority if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in = accept;

   mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_pixel_in),
      .rd_addr (col_ff),
      .rd_data (a_rd)
   );

   // older row gets the previous row's word once it has been read out
   mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (a_rd),
      .rd_addr (col_ff),
      .rd_data (b_rd)
   );

   always_comb begin
      cols[WIN_TOP] = s1_fwd_ff ? fwd_b_ff : b_rd;
      cols[WIN_MID] = a_rd;
      cols[WIN_BOT] = s1_px_ff;
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            if (s1_first_ff) begin
               win_in[r][COL_OLD] = cols[r];
               win_in[r][COL_CEN] = cols[r];
            end else begin
               win_in[r][COL_OLD] = win_ff[r][COL_CEN];
               win_in[r][COL_CEN] = win_ff[r][COL_NEW];
            end
            win_in[r][COL_NEW] = cols[r];
         end
      end
   end

   assign job_push       = s1_valid_ff && (s1_needs_ff != '0);
   assign job.win        = win_in;
   assign job.needs      = s1_needs_ff;
   assign job.up_top_mid = s1_up_top_mid_ff;
   assign job.lo_top_bot = s1_lo_top_bot_ff;
   assign job.frame_end  = s1_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff         <= req_pixel_in;
         s1_idx_ff        <= col_ff;
         s1_first_ff      <= col_ff == '0;
         // same column back to back: the older-row write is not yet in the store
         s1_fwd_ff        <= s1_valid_ff && (s1_idx_ff == col_ff);
         fwd_b_ff         <= a_rd;
         s1_needs_ff      <= needs;
         s1_up_top_mid_ff <= row_ff == ROW_W'(1);
         s1_lo_top_bot_ff <= row_ff == '0;
         s1_frame_end_ff  <= last_row && last_col;
      end
   end

endmodule

FILE: sv/mf3_jobq.sv
// Short job queue between the front end and the median back end.
module mf3_jobq import mf3_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head,
   output logic [QCNT_W-1:0] count
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head  = slot_ff[rptr_ff];
   assign count = count_ff;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/mf3_back.sv
// Back end: steps through the results of each job, two-stage median, result queue.
module mf3_back import mf3_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  job_type           head,
   input  logic [QCNT_W-1:0] q_count,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pix_type           rsp_median_out,
   output logic              rsp_frame_done,
   output logic              rsp_run_last
);

   logic [3:0]  done_ff, done_in, pend, sel_mask, rest;
   logic [1:0]  sel_code;
   logic        issue, is_last, upper, edge_col;
   logic [OCNT_W-1:0] occ;
   logic [2:0][1:0] rs, cs;
   window_type  taps;
   trio_type    srt0, srt1, srt2;

   logic        sa_valid_ff;
   trio_type    sa_row0_ff, sa_row1_ff, sa_row2_ff;
   logic        sa_run_last_ff, sa_frame_done_ff;
   rsp_type     med_word;

   rsp_type             of_ff [ODEPTH];
   logic [OPTR_W-1:0]   of_wptr_ff, of_wptr_in, of_rptr_ff, of_rptr_in;
   logic [OCNT_W-1:0]   of_count_ff, of_count_in;
   logic                of_pop;

   assign pend = head.needs & ~done_ff;
   assign occ  = of_count_ff + OCNT_W'(sa_valid_ff);
   assign issue = (q_count != '0) && (occ < OCNT_W'(ODEPTH));

   always_comb begin
      priority if (pend[RES_UP_INNER]) begin
         sel_code = RES_UP_INNER;
      end else if (pend[RES_UP_EDGE]) begin
         sel_code = RES_UP_EDGE;
      end else if (pend[RES_LO_INNER]) begin
         sel_code = RES_LO_INNER;
      end else begin
         sel_code = RES_LO_EDGE;
      end
      sel_mask = 4'b0001 << sel_code;
      rest     = pend & ~sel_mask;
      is_last  = rest == '0;
      q_pop    = issue && is_last;
      done_in  = done_ff;
      if (issue) begin
         done_in = is_last ? '0 : (done_ff | sel_mask);
      end
   end

   // pick the nine taps with edge clamping for the chosen slot
   always_comb begin
      upper    = !sel_code[1];
      edge_col = sel_code[0];
      if (upper) begin
         rs[0] = head.up_top_mid ? WIN_MID : WIN_TOP;
         rs[1] = WIN_MID;
      end else begin
         rs[0] = head.lo_top_bot ? WIN_BOT : WIN_MID;
         rs[1] = WIN_BOT;
      end
      rs[2] = WIN_BOT;
      if (edge_col) begin
         cs[0] = COL_CEN;
         cs[1] = COL_NEW;
      end else begin
         cs[0] = COL_OLD;
         cs[1] = COL_CEN;
      end
      cs[2] = COL_NEW;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            taps[i][j] = head.win[rs[i]][cs[j]];
         end
      end
      srt0 = sort3(taps[0][0], taps[0][1], taps[0][2]);
      srt1 = sort3(taps[1][0], taps[1][1], taps[1][2]);
      srt2 = sort3(taps[2][0], taps[2][1], taps[2][2]);
   end

   // median of nine from three sorted rows
   always_comb begin
      med_word.median = med3(max3(sa_row0_ff[0], sa_row1_ff[0], sa_row2_ff[0]),
                             med3(sa_row0_ff[1], sa_row1_ff[1], sa_row2_ff[1]),
                             min3(sa_row0_ff[2], sa_row1_ff[2], sa_row2_ff[2]));
      med_word.frame_done = sa_frame_done_ff;
      med_word.run_last   = sa_run_last_ff;
   end

   assign rsp_empty      = of_count_ff == '0;
   assign of_pop         = rsp_pop && !rsp_empty;
   assign rsp_median_out = of_ff[of_rptr_ff].median;
   assign rsp_frame_done = of_ff[of_rptr_ff].frame_done;
   assign rsp_run_last   = of_ff[of_rptr_ff].run_last;

   always_comb begin
      of_wptr_in  = sa_valid_ff ? of_wptr_ff + 1'b1 : of_wptr_ff;
      of_rptr_in  = of_pop ? of_rptr_ff + 1'b1 : of_rptr_ff;
      of_count_in = of_count_ff + OCNT_W'(sa_valid_ff) - OCNT_W'(of_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= '0;
         sa_valid_ff <= 1'b0;
         of_wptr_ff  <= '0;
         of_rptr_ff  <= '0;
         of_count_ff <= '0;
      end else begin
         done_ff     <= done_in;
         sa_valid_ff <= issue;
         of_wptr_ff  <= of_wptr_in;
         of_rptr_ff  <= of_rptr_in;
         of_count_ff <= of_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         sa_row0_ff       <= srt0;
         sa_row1_ff       <= srt1;
         sa_row2_ff       <= srt2;
         sa_run_last_ff   <= is_last;
         sa_frame_done_ff <= is_last && head.frame_end;
      end
      if (sa_valid_ff) begin
         of_ff[of_wptr_ff] <= med_word;
      end
   end

endmodule

FILE: sv/median_filter_3x3_clamped_unit.sv
// Streaming 3x3 median filter for 8-bit grey frames, edge pixels replicated.
// Pixels enter in raster order at up to one word per clock. Each pixel's median
// word leaves once the pixel right and below it (clamped to the frame) has been
// taken, so results trail the input by one row and one column. Most pixels
// release one result; the last column releases two and the last row up to
// four, which the median unit issues one per clock while the result queue has
// room, so with prompt pops the input sees back pressure only in the final row.
// Row history is kept in two 1024 x 8 RAMs that need no clearing after reset.
// Writing image_width or image_height restarts the frame at pixel (0,0); write
// them only while the block is idle.
module median_filter_3x3_clamped_unit import mf3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  pix_type               req_pixel_in,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output pix_type               rsp_median_out,
   output logic                  rsp_frame_done,
   output logic                  rsp_run_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              job_push, q_pop;
   job_type           job, head;
   logic [QCNT_W-1:0] q_count;

   mf3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_pixel_in (req_pixel_in),
      .req_full     (req_full),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_count      (q_count),
      .job_push     (job_push),
      .job          (job)
   );

   mf3_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head     (head),
      .count    (q_count)
   );

   mf3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_count        (q_count),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_median_out (rsp_median_out),
      .rsp_frame_done (rsp_frame_done),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

FILE: sv/mf3_checker.sv
// Port-level checks for the median filter, bound to the top level.
module mf3_checker import mf3_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input pix_type rsp_median_out,
   input logic    rsp_frame_done,
   input logic    rsp_run_last
);

   // nothing waits and input is open right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("block not clear after reset");

   // end of frame is always the last word of its input
   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> rsp_run_last)
      else $error("frame_done without run_last");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result word withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_median_out) && $stable(rsp_frame_done)
                                    && $stable(rsp_run_last)))
      else $error("stalled result word changed");

endmodule

bind median_filter_3x3_clamped_unit mf3_checker u_mf3_checker (.*);

FILE: verif/tb_median_filter_3x3_clamped_unit.sv
// Self-checking testbench for the streaming 3x3 median filter with edge clamping.
module tb_median_filter_3x3_clamped_unit;
   import mf3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 80;
   localparam int MAX_REPORTS   = 10;

   // index with no register behind it; a write must leave the frame alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   pix_type               req_pixel_in = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   pix_type               rsp_median_out;
   logic                  rsp_frame_done;
   logic                  rsp_run_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   median_filter_3x3_clamped_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_pixel_in   (req_pixel_in),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_median_out (rsp_median_out),
      .rsp_frame_done (rsp_frame_done),
      .rsp_run_last   (rsp_run_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // filter state as the block should hold it
   pix_type                 prev_row  [MAX_WIDTH];
   pix_type                 older_row [MAX_WIDTH];
   pix_type                 taps [3][3];   // [row][col], col 2 newest
   int unsigned             pos_row;
   int unsigned             pos_col;
   logic [WIDTH_REG_W-1:0]  width_cfg;
   logic [HEIGHT_REG_W-1:0] height_cfg;

   rsp_type medians_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      idling_on   = 1'b1;
   int      pop_hold    = 0;
   rsp_type got_word;
   rsp_type want_word;

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_cfg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = height_cfg;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   // fifth smallest of the nine selected taps, found by rank counting
   function automatic pix_type neighbourhood_median(input int t, input int m, input int b,
                                                    input int c0, input int c1, input int c2);
      pix_type v[9];
      int      rsel[3];
      int      csel[3];
      int      i;
      int      j;
      int      lt;
      int      le;
      rsel = '{t, m, b};
      csel = '{c0, c1, c2};
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            v[i*3+j] = taps[rsel[i]][csel[j]];
      for (i = 0; i < 9; i++) begin
         lt = 0;
         le = 0;
         for (j = 0; j < 9; j++) begin
            if (v[j] < v[i]) lt++;
            if (v[j] <= v[i]) le++;
         end
         if (lt <= 4 && le >= 5) return v[i];
      end
      return v[4];
   endfunction

   function automatic void predict_pixel(input pix_type px);
      int unsigned w;
      int unsigned h;
      int unsigned ic;
      int unsigned ir;
      int          top;
      int          n;
      int          r;
      bit          last_col;
      bit          last_row;
      pix_type     newcol[3];
      rsp_type     words[4];
      w  = eff_width();
      h  = eff_height();
      ic = pos_col;
      ir = pos_row;
      last_col = (ic + 1 >= w);
      last_row = (ir + 1 >= h);

      newcol[0] = older_row[ic];
      newcol[1] = prev_row[ic];
      newcol[2] = px;
      older_row[ic] = prev_row[ic];
      prev_row[ic]  = px;

      for (r = 0; r < 3; r++) begin
         if (ic == 0) begin
            taps[r][0] = newcol[r];
            taps[r][1] = newcol[r];
            taps[r][2] = newcol[r];
         end else begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
            taps[r][2] = newcol[r];
         end
      end

      for (r = 0; r < 4; r++) words[r] = '0;
      n = 0;
      // row above the input row; its top is clamped when it is row 0
      if (ir >= 1) begin
         top = (ir == 1) ? 1 : 0;
         if (ic >= 1) begin
            words[n].median = neighbourhood_median(top, 1, 2, 0, 1, 2);
            n++;
         end
         if (last_col) begin
            words[n].median = neighbourhood_median(top, 1, 2, 1, 2, 2);
            n++;
         end
      end
      // last frame row: bottom clamped to itself
      if (last_row) begin
         top = (ir == 0) ? 2 : 1;
         if (ic >= 1) begin
            words[n].median = neighbourhood_median(top, 2, 2, 0, 1, 2);
            n++;
         end
         if (last_col) begin
            words[n].median = neighbourhood_median(top, 2, 2, 1, 2, 2);
            n++;
         end
      end
      if (n > 0) begin
         words[n-1].run_last = 1'b1;
         if (last_row && last_col) words[n-1].frame_done = 1'b1;
      end
      for (r = 0; r < n; r++) medians_due.push_back(words[r]);

      if (last_col) begin
         pos_col = 0;
         pos_row = last_row ? 0 : ((ir + 1) & 12'hFFF);
      end else begin
         pos_col = (ic + 1) & 10'h3FF;
      end
   endfunction

   function automatic pix_type random_pixel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input pix_type px);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (req_full);
      predict_pixel(px);
   endtask

   // stop sending, let every expected word drain, then let the pipe settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (medians_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // hold keeps valid high for a following write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data, input bit hold);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (!hold) csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_cfg = data[WIDTH_REG_W-1:0];
            pos_row = 0;
            pos_col = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            height_cfg = data[HEIGHT_REG_W-1:0];
            pos_row = 0;
            pos_col = 0;
         end
         default: ;
      endcase
   endtask

   task automatic send_pixels(input int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // reset geometry of 256 x 256: part of the first row, nothing released yet
   task automatic test_default_geometry();
      send_pixels(8);
      wait_idle();
   endtask

   task automatic test_edge_cases();
      pix_type grid[9];
      int      i;
      grid = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254};
      // 3x3 frame: last pixel releases four words, rows interleaved
      write_csr(CSR_IMAGE_WIDTH, 13'd3, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3, 1'b0);
      for (i = 0; i < 9; i++) send_pixel(grid[i]);
      wait_idle();
      // zero sizes act as 1x1; two frames back to back wrap the position
      write_csr(CSR_IMAGE_WIDTH, 13'd0, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd0, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 13'd2, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd2, 1'b0);
      send_pixels(4);
      wait_idle();
   endtask

   task automatic test_config_restart();
      write_csr(CSR_IMAGE_WIDTH, 13'd3, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd2, 1'b0);
      send_pixels(4);
      wait_idle();
      // rewrite restarts at (0,0); upper data bits beyond the width field are dropped
      write_csr(CSR_IMAGE_WIDTH, 13'h1803, 1'b0);
      send_pixels(2);
      wait_idle();
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 8191)), 1'b0);
      send_pixels(4);
      wait_idle();
   endtask

   task automatic test_extreme_geometry();
      // oversize width clamps to the line store length; start of a single-row frame
      write_csr(CSR_IMAGE_WIDTH, 13'h07FF, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd1, 1'b0);
      send_pixels(20);
      wait_idle();
      // one pixel wide, oversize height clamps to the tallest frame; top rows only
      write_csr(CSR_IMAGE_WIDTH, 13'h1801, 1'b1);
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF, 1'b0);
      idling_on = 1'b0;
      send_pixels(20);
      wait_idle();
      idling_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int                      sent;
      int                      sel;
      int                      npix;
      int                      k;
      logic [1:0]              junk;
      logic [WIDTH_REG_W-1:0]  w_val;
      logic [HEIGHT_REG_W-1:0] h_val;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idling_on = (sent < RANDOM_ITEMS * 2 / 3);
         sel = $urandom_range(0, 9);
         if (sel == 0) w_val = WIDTH_REG_W'($urandom_range(0, 1));
         else if (sel == 1) w_val = WIDTH_REG_W'($urandom_range(9, 24));
         else w_val = WIDTH_REG_W'($urandom_range(2, 8));
         h_val = (sel == 1) ? HEIGHT_REG_W'($urandom_range(1, 3))
                            : HEIGHT_REG_W'($urandom_range(0, 6));
         junk = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 4) != 0) write_csr(CSR_IMAGE_WIDTH, {junk, w_val}, 1'b1);
         write_csr(CSR_IMAGE_HEIGHT, h_val, 1'b0);
         npix = eff_width() * eff_height() * $urandom_range(1, 2);
         // now and then a broken frame, cut short by the next restart
         if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
         if (npix > RANDOM_ITEMS - sent) npix = RANDOM_ITEMS - sent;
         for (k = 0; k < npix; k++) send_pixel(random_pixel());
         sent += npix;
         wait_idle();
      end
   endtask

   // result side: random pop stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold = 0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         pop_hold = $urandom_range(1, 6) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         got_word.median     = rsp_median_out;
         got_word.frame_done = rsp_frame_done;
         got_word.run_last   = rsp_run_last;
         if (medians_due.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected word: median %0d frame_done %b run_last %b",
                        got_word.median, got_word.frame_done, got_word.run_last);
         end else begin
            want_word = medians_due.pop_front();
            if (got_word !== want_word) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("word mismatch: expected median %0d frame_done %b run_last %b, %s",
                           want_word.median, want_word.frame_done, want_word.run_last,
                           $sformatf("got median %0d frame_done %b run_last %b",
                                     got_word.median, got_word.frame_done,
                                     got_word.run_last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < MAX_WIDTH; i++) begin
         prev_row[i]  = '0;
         older_row[i] = '0;
      end
      for (i = 0; i < 9; i++) taps[i/3][i%3] = '0;
      pos_row    = 0;
      pos_col    = 0;
      width_cfg  = WIDTH_RESET;
      height_cfg = HEIGHT_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_geometry();
      test_edge_cases();
      test_config_restart();
      test_extreme_geometry();
      test_random_frames();

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/mf3_pkg.sv
sv/mf3_ram.sv
sv/mf3_front.sv
sv/mf3_jobq.sv
sv/mf3_back.sv
sv/median_filter_3x3_clamped_unit.sv
sv/mf3_checker.sv
verif/tb_median_filter_3x3_clamped_unit.sv
